FILE: hdl/srpw_pkg.sv
// Package: shared types and constants for the stroke ribbon block.
`default_nettype none
package srpw_pkg;
    localparam int AtanTabLen = 24;
    localparam int WidthBits = 16;
    localparam int GainBits = 8;
    localparam logic [GainBits-1:0] GainReset = 8'd51;
    localparam logic [31:0] CordicK = 32'd652032875;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Command from front to back part
    typedef enum logic [1:0] {
        CMD_PAIR  = 2'd0,  // prime heading from held 0->1, emit held 0
        CMD_MID   = 2'd1,  // segment held1->p, smooth, emit held 1
        CMD_END   = 2'd2   // smooth again with last segment, emit p (end)
    } t_cmd;
endpackage
`default_nettype wire

FILE: hdl/srpw_front.sv
// Front part: holds points, classifies each point into back-end commands.
`default_nettype none
module srpw_front
    import srpw_pkg::*;
#(
    parameter int CoordBits = 20
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire [CoordBits-1:0]   i_x,
    input  wire [CoordBits-1:0]   i_y,
    input  wire [WidthBits-1:0]   i_w,
    input  wire                   i_first,
    input  wire                   i_last,
    // command queue write side
    output logic                  o_cmd_valid,
    input  wire                   i_cmd_ready,
    output t_cmd                  o_cmd,
    output logic [CoordBits-1:0]  o_ax,
    output logic [CoordBits-1:0]  o_ay,
    output logic [CoordBits-1:0]  o_bx,
    output logic [CoordBits-1:0]  o_by,
    output logic [CoordBits-1:0]  o_ex,
    output logic [CoordBits-1:0]  o_ey,
    output logic [WidthBits-1:0]  o_ew
);
    localparam int PW = 2*CoordBits + WidthBits;
    typedef enum logic [1:0] {S_IDLE, S_PAIR, S_MID, S_END} t_state;
    t_state r_state;
    logic [PW-1:0] r_h0, r_h1, r_p;
    logic [1:0] r_seen;
    logic r_last;

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd_valid = (r_state != S_IDLE);

    always_comb begin
        o_cmd = CMD_MID;
        o_ax = r_h1[CoordBits-1:0];
        o_ay = r_h1[2*CoordBits-1:CoordBits];
        o_bx = r_p[CoordBits-1:0];
        o_by = r_p[2*CoordBits-1:CoordBits];
        o_ex = r_h1[CoordBits-1:0];
        o_ey = r_h1[2*CoordBits-1:CoordBits];
        o_ew = r_h1[PW-1:2*CoordBits];
        unique case (r_state)
            S_PAIR: begin
                o_cmd = CMD_PAIR;
                o_ax = r_h0[CoordBits-1:0];
                o_ay = r_h0[2*CoordBits-1:CoordBits];
                o_bx = r_h1[CoordBits-1:0];
                o_by = r_h1[2*CoordBits-1:CoordBits];
                o_ex = r_h0[CoordBits-1:0];
                o_ey = r_h0[2*CoordBits-1:CoordBits];
                o_ew = r_h0[PW-1:2*CoordBits];
            end
            S_END: begin
                o_cmd = CMD_END;
                o_ex = r_p[CoordBits-1:0];
                o_ey = r_p[2*CoordBits-1:CoordBits];
                o_ew = r_p[PW-1:2*CoordBits];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen <= 2'd0;
            r_last <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_last <= i_last;
                    r_p <= {i_w, i_y, i_x};
                    if (i_first || r_seen == 2'd0) begin
                        r_h0 <= {i_w, i_y, i_x};
                        r_seen <= i_last ? 2'd0 : 2'd1;
                    end else if (r_seen == 2'd1) begin
                        r_h1 <= {i_w, i_y, i_x};
                        r_seen <= i_last ? 2'd0 : 2'd2;
                    end else begin
                        r_state <= (r_seen == 2'd2) ? S_PAIR : S_MID;
                    end
                end
                S_PAIR: if (i_cmd_ready) r_state <= S_MID;
                S_MID: if (i_cmd_ready) begin
                    r_h0 <= r_h1;
                    r_h1 <= r_p;
                    r_seen <= r_last ? 2'd0 : 2'd3;
                    r_state <= r_last ? S_END : S_IDLE;
                end
                S_END: if (i_cmd_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/srpw_back.sv
// Back part: iterative CORDIC atan2, smoothing, sincos, vertex offsets.
`default_nettype none
module srpw_back
    import srpw_pkg::*;
#(
    parameter int CoordBits = 20,
    parameter int AngleBits = 16,
    parameter int CordicStages = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [GainBits-1:0]    i_gain,
    input  wire                   i_cmd_valid,
    output logic                  o_cmd_ready,
    input  wire t_cmd             i_cmd,
    input  wire [CoordBits-1:0]   i_ax,
    input  wire [CoordBits-1:0]   i_ay,
    input  wire [CoordBits-1:0]   i_bx,
    input  wire [CoordBits-1:0]   i_by,
    input  wire [CoordBits-1:0]   i_ex,
    input  wire [CoordBits-1:0]   i_ey,
    input  wire [WidthBits-1:0]   i_ew,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [CoordBits-1:0]  o_lx,
    output logic [CoordBits-1:0]  o_ly,
    output logic [CoordBits-1:0]  o_rx,
    output logic [CoordBits-1:0]  o_ry,
    output logic                  o_end
);
    localparam int Stages = (CordicStages < AtanTabLen) ? CordicStages : AtanTabLen;
    localparam int SB = $clog2(Stages + 1);
    localparam int VW = CoordBits + 24;  // vector magnitude bits with prescale
    localparam int PW = 32 + WidthBits + 1;
    localparam logic signed [CoordBits:0] SatHi = (CoordBits+1)'((64'sd1 <<< (CoordBits-1)) - 1);
    localparam logic signed [CoordBits:0] SatLo = (CoordBits+1)'(-(64'sd1 <<< (CoordBits-1)));

    typedef enum logic [2:0] {S_IDLE, S_ATAN, S_SMOOTH, S_SC, S_MUL, S_SUM, S_OUT} t_state;
    t_state r_state;
    t_cmd r_cmd;
    logic [SB-1:0] r_i;
    logic signed [VW-1:0] r_vx, r_vy;
    logic [31:0] r_z;
    logic signed [33:0] r_sz;
    logic signed [32:0] r_cx, r_cy;
    logic r_neg;
    logic [AngleBits-1:0] r_smooth, r_seg;
    logic signed [CoordBits-1:0] r_px, r_py;
    logic [WidthBits-1:0] r_w;
    logic signed [PW-1:0] r_mx, r_my;
    logic r_zero;
    logic [31:0] w_tab;
    logic [AngleBits-1:0] w_h;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_tab = atan_tab(5'(r_i));
    assign w_h = AngleBits'(((r_z + (32'd1 << (31 - AngleBits))) >> (32 - AngleBits)));

    // smoothing step
    logic signed [AngleBits-1:0] w_d;
    logic signed [AngleBits+GainBits+1:0] w_prod;
    logic [AngleBits-1:0] w_sm;
    always_comb begin
        w_d = $signed(r_seg - r_smooth);
        w_prod = $signed({1'b0, i_gain}) * w_d + (AngleBits+GainBits+2)'(128);
        w_sm = r_smooth + AngleBits'(w_prod >>> 8);
    end

    // rounding/saturation
    logic signed [PW-1:0] w_ox, w_oy;
    logic signed [CoordBits+1:0] w_s0, w_s1, w_s2, w_s3;
    function automatic logic [CoordBits-1:0] sat(input logic signed [CoordBits+1:0] v);
        if (v > SatHi) return SatHi[CoordBits-1:0];
        if (v < SatLo) return SatLo[CoordBits-1:0];
        return v[CoordBits-1:0];
    endfunction
    always_comb begin
        w_ox = (r_mx + (PW'(1) <<< 30)) >>> 31;
        w_oy = (r_my + (PW'(1) <<< 30)) >>> 31;
        w_s0 = (CoordBits+2)'(r_px) + (CoordBits+2)'(w_ox);
        w_s1 = (CoordBits+2)'(r_py) + (CoordBits+2)'(w_oy);
        w_s2 = (CoordBits+2)'(r_px) - (CoordBits+2)'(w_ox);
        w_s3 = (CoordBits+2)'(r_py) - (CoordBits+2)'(w_oy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_smooth <= '0;
            r_seg <= '0;
        end else begin
            if (o_valid && i_ready && r_state != S_SUM) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_px <= $signed(i_ex);
                    r_py <= $signed(i_ey);
                    r_w <= i_ew;
                    r_i <= '0;
                    if (i_cmd == CMD_END) begin
                        r_state <= S_SMOOTH;
                    end else begin
                        r_vx <= (VW'($signed(i_bx)) - VW'($signed(i_ax))) <<< 20;
                        r_vy <= (VW'($signed(i_by)) - VW'($signed(i_ay))) <<< 20;
                        r_zero <= (i_bx == i_ax) && (i_by == i_ay);
                        r_z <= '0;
                        r_state <= S_ATAN;
                    end
                end
                S_ATAN: begin
                    if (r_i == '0 && r_vx < 0) begin
                        r_vx <= -r_vx;
                        r_vy <= -r_vy;
                        r_z <= 32'h8000_0000;
                        r_i <= SB'(0);
                        r_state <= S_ATAN;
                    end
                    if (!(r_i == '0 && r_vx < 0)) begin
                        if (r_i == SB'(Stages)) begin
                            if (r_cmd == CMD_PAIR) begin
                                r_smooth <= r_zero ? '0 : w_h;
                                r_state <= S_SC;
                            end else begin
                                r_seg <= r_zero ? '0 : w_h;
                                r_state <= S_SMOOTH;
                            end
                            r_i <= '0;
                        end else begin
                            if (r_vy > 0) begin
                                r_vx <= r_vx + (r_vy >>> r_i);
                                r_vy <= r_vy - (r_vx >>> r_i);
                                r_z <= r_z + w_tab;
                            end else begin
                                r_vx <= r_vx - (r_vy >>> r_i);
                                r_vy <= r_vy + (r_vx >>> r_i);
                                r_z <= r_z - w_tab;
                            end
                            r_i <= r_i + SB'(1);
                        end
                    end
                end
                S_SMOOTH: begin
                    r_smooth <= w_sm;
                    r_i <= '0;
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (r_i == SB'(Stages)) begin
                        r_cx <= r_neg ? -r_cx : r_cx;
                        r_cy <= r_neg ? -r_cy : r_cy;
                        r_state <= S_MUL;
                    end else begin
                        if (r_sz >= 0) begin
                            r_cx <= r_cx - (r_cy >>> r_i);
                            r_cy <= r_cy + (r_cx >>> r_i);
                            r_sz <= r_sz - $signed({2'b00, w_tab});
                        end else begin
                            r_cx <= r_cx + (r_cy >>> r_i);
                            r_cy <= r_cy - (r_cx >>> r_i);
                            r_sz <= r_sz + $signed({2'b00, w_tab});
                        end
                        r_i <= r_i + SB'(1);
                    end
                end
                S_MUL: begin
                    r_mx <= -(PW'(r_cy) * $signed({1'b0, r_w}));
                    r_my <= PW'(r_cx) * $signed({1'b0, r_w});
                    r_state <= S_SUM;
                end
                // waits here while the previous pair sits unaccepted
                S_SUM: if (!o_valid || i_ready) begin
                    o_lx <= sat(w_s0);
                    o_ly <= sat(w_s1);
                    o_rx <= sat(w_s2);
                    o_ry <= sat(w_s3);
                    o_end <= (r_cmd == CMD_END);
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // sincos setup, taken when entering S_SC
            if ((r_state == S_SMOOTH) || (r_state == S_ATAN && r_i == SB'(Stages)
                    && r_cmd == CMD_PAIR)) begin
                logic [31:0] a2;
                logic signed [33:0] z2;
                a2 = (r_state == S_SMOOTH) ? {w_sm, {(32-AngleBits){1'b0}}}
                                           : {(r_zero ? {AngleBits{1'b0}} : w_h),
                                              {(32-AngleBits){1'b0}}};
                z2 = $signed({{2{a2[31]}}, a2});
                r_cx <= $signed({1'b0, CordicK});
                r_cy <= '0;
                if (z2 > 34'sd1073741824) begin
                    r_sz <= z2 - 34'sd2147483648;
                    r_neg <= 1'b1;
                end else if (z2 < -34'sd1073741824) begin
                    r_sz <= z2 + 34'sd2147483648;
                    r_neg <= 1'b1;
                end else begin
                    r_sz <= z2;
                    r_neg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/stroke_ribbon_point_width.sv
// Top level: stroke ribbon expansion with smoothed heading.
// Each point is classified by the front part into zero to three vertex-pair
// requests; a new point is taken only after the front part has handed all
// requests of the previous point to the back part. Per pair the back part
// takes the request, runs iterative atan2 (with an extra step when the segment
// points toward negative x), a smoothing step, iterative sincos, a multiply and
// a rounding step. The first pair of a stroke skips smoothing; the end pair
// skips the atan2. The rounding step waits while the previous pair is
// unaccepted at the output. Reset loads smooth_gain with 51.
`default_nettype none
module stroke_ribbon_point_width
    import srpw_pkg::*;
#(
    parameter int COORD_BITS = 20,
    parameter int ANGLE_BITS = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [GainBits-1:0]       i_cfg_wdata,
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // point_x, point_y, point_width, zero fill
    input  wire [((2*COORD_BITS+WidthBits+7)/8)*8-1:0] s_axis_tdata,
    input  wire                      s_axis_tuser,   // first_point
    input  wire                      s_axis_tlast,   // last_point
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // left_x, left_y, right_x, right_y, zero fill
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                     m_axis_tlast    // stroke_end
);
    localparam int OW = ((4*COORD_BITS+7)/8)*8;
    logic [GainBits-1:0] r_gain;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gain <= GainReset;
        else if (i_cfg_we) r_gain <= i_cfg_wdata;
    end

    logic c_valid, c_ready;
    t_cmd c_cmd;
    logic [COORD_BITS-1:0] ax, ay, bx, by, ex, ey, lx, ly, rx, ry;
    logic [WidthBits-1:0] ew;

    srpw_front #(.CoordBits(COORD_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_x(s_axis_tdata[COORD_BITS-1:0]),
        .i_y(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_w(s_axis_tdata[2*COORD_BITS+WidthBits-1:2*COORD_BITS]),
        .i_first(s_axis_tuser), .i_last(s_axis_tlast),
        .o_cmd_valid(c_valid), .i_cmd_ready(c_ready), .o_cmd(c_cmd),
        .o_ax(ax), .o_ay(ay), .o_bx(bx), .o_by(by),
        .o_ex(ex), .o_ey(ey), .o_ew(ew)
    );

    srpw_back #(.CoordBits(COORD_BITS), .AngleBits(ANGLE_BITS),
                .CordicStages(CORDIC_STAGES)) u_back (
        .i_clk, .i_rst_n, .i_gain(r_gain),
        .i_cmd_valid(c_valid), .o_cmd_ready(c_ready), .i_cmd(c_cmd),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_ex(ex), .i_ey(ey), .i_ew(ew),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_lx(lx), .o_ly(ly), .o_rx(rx), .o_ry(ry), .o_end(m_axis_tlast)
    );

    assign m_axis_tdata = OW'({ry, rx, ly, lx});
endmodule
`default_nettype wire
